### sv/content_disposition_tokenizer_top_macros.svh
//------------------------------------------------------------------------------
// content_disposition_tokenizer_top_macros.svh
// Assertion macros shared by the tokenizer RTL.
//------------------------------------------------------------------------------
`ifndef CONTENT_DISPOSITION_TOKENIZER_TOP_MACROS_SVH
`define CONTENT_DISPOSITION_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdt assertion failed");

// Next-cycle implication, disabled during reset.
`define CDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdt assertion failed");

`endif

### sv/cdt_pkg.sv
//------------------------------------------------------------------------------
// cdt_pkg
// Types, codes and byte classification for the Content-Disposition tokenizer.
//------------------------------------------------------------------------------
package cdt_pkg;

    localparam int HEADER_BYTES = 4096;
    localparam int POS_W        = 13;
    localparam int POS_LIMIT    = (HEADER_BYTES < 8191) ? HEADER_BYTES : 8191;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_LIMIT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_END  = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        CLS_WS,
        CLS_LF,
        CLS_CR,
        CLS_NUL,
        CLS_SEMI,
        CLS_EQ,
        CLS_DQUOTE,
        CLS_BSLASH,
        CLS_SEP,
        CLS_OTHER
    } t_cls;

    typedef enum logic [3:0] {
        PS_FTYPE  = 4'd0,
        PS_TYPE   = 4'd1,
        PS_ETYPE  = 4'd2,
        PS_FPARAM = 4'd3,
        PS_PARAM  = 4'd4,
        PS_EPARAM = 4'd5,
        PS_FVAL   = 4'd6,
        PS_FQVAL  = 4'd7,
        PS_QVAL   = 4'd8,
        PS_SKIPQ  = 4'd9,
        PS_VAL    = 4'd10,
        PS_EVAL   = 4'd11,
        PS_LF     = 4'd12,
        PS_CR     = 4'd13,
        PS_CRLF   = 4'd14
    } t_pstate;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_TYPE_START = 3'd1,
        EV_TYPE_END   = 3'd2,
        EV_NAME_START = 3'd3,
        EV_NAME_END   = 3'd4,
        EV_VAL_START  = 3'd5,
        EV_VAL_END    = 3'd6,
        EV_DONE       = 3'd7
    } t_event;

    typedef struct packed {
        t_cmd cmd;
        t_cls cls;
    } t_item;

    function automatic t_cls classify(input logic [7:0] ch);
        t_cls cls;
        case (ch)
            CH_SPACE, CH_TAB: cls = CLS_WS;
            CH_LF:            cls = CLS_LF;
            CH_CR:            cls = CLS_CR;
            CH_NUL:           cls = CLS_NUL;
            CH_SEMI:          cls = CLS_SEMI;
            CH_EQ:            cls = CLS_EQ;
            CH_DQUOTE:        cls = CLS_DQUOTE;
            CH_BSLASH:        cls = CLS_BSLASH;
            CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_AT, CH_COMMA, CH_COLON,
            CH_SLASH, CH_LBRACK, CH_RBRACK, CH_QMARK, CH_LBRACE, CH_RBRACE:
                              cls = CLS_SEP;
            default:          cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

### sv/content_disposition_tokenizer_top.sv
//------------------------------------------------------------------------------
// Content-Disposition header tokenizer
// Takes one header byte (or an end-of-header marker) per beat and returns
// one result beat per input beat: a token boundary event, the byte position,
// a quoted flag and a sticky error flag. It sustains one beat per clock while
// neither side stalls; each result passes through the input classify register,
// the two-entry item queue and the parser output register, and
// either side may stall without holding up the other while the queue has room.
//------------------------------------------------------------------------------
`include "content_disposition_tokenizer_top_macros.svh"

module content_disposition_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [0:0]  i_cmd,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [12:0] o_position,
    output logic        o_quoted,
    output logic        o_error
);
    import cdt_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_item w_front_item;
    t_item w_queue_item;
    logic  w_ev_quiet;

    assign w_ev_quiet = (o_event_res == EV_NONE) || (o_event_res == EV_DONE);

    cdt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_char_in (i_char_in),
        .o_push    (w_push),
        .o_item    (w_front_item),
        .i_full    (w_full)
    );

    cdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_empty (w_empty)
    );

    cdt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_event_res (o_event_res),
        .o_position  (o_position),
        .o_quoted    (o_quoted),
        .o_error     (o_error)
    );

    `CDT_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, w_push, !w_full)
    `CDT_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_empty)
    `CDT_ASSERT_NOW(a_error_no_token, i_clk, i_rst_n, o_valid && o_error, w_ev_quiet)
    `CDT_ASSERT_NEXT(a_pop_fills_output, i_clk, i_rst_n, w_pop, o_valid)

endmodule

### sv/cdt_front.sv
//------------------------------------------------------------------------------
// cdt_front
// Input stage: accept a beat, classify the byte, hand the item to the queue.
//------------------------------------------------------------------------------
module cdt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [0:0]     i_cmd,
    input  logic [7:0]     i_char_in,
    output logic           o_push,
    output cdt_pkg::t_item o_item,
    input  logic           i_full
);
    import cdt_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    assign o_ready  = !r_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = r_valid && !i_full;
    assign o_item   = r_item;

    always_comb begin
        n_valid = w_accept || (r_valid && i_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd <= t_cmd'(i_cmd);
            r_item.cls <= classify(i_char_in);
        end
    end

endmodule

### sv/cdt_queue.sv
//------------------------------------------------------------------------------
// cdt_queue
// Short FIFO of classified items between the front and back stages.
//------------------------------------------------------------------------------
module cdt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cdt_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output cdt_pkg::t_item o_item,
    output logic           o_empty
);
    import cdt_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wptr;
    logic [QPTR_W-1:0]  n_rptr;
    logic [QCNT_W-1:0]  n_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### sv/cdt_back.sv
//------------------------------------------------------------------------------
// cdt_back
// Parse stage: run the header state machine on each queued item and
// register one result per item.
//------------------------------------------------------------------------------
module cdt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  cdt_pkg::t_item    i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_event_res,
    output logic [12:0]       o_position,
    output logic              o_quoted,
    output logic              o_error
);
    import cdt_pkg::*;

    t_pstate           r_pstate;
    t_pstate           r_fold;
    logic [POS_W-1:0]  r_offset;
    logic              r_err;
    t_pstate           n_pstate;
    t_pstate           n_fold;
    logic [POS_W-1:0]  n_offset;
    logic              n_err;

    logic              r_out_valid;
    logic              n_out_valid;
    t_event            r_event;
    logic [POS_W-1:0]  r_pos;
    logic              r_quoted;
    logic              r_error;
    t_event            n_event;
    logic              n_quoted;
    logic              n_error;

    t_pstate           w_ns;
    t_pstate           w_nf;
    t_pstate           w_fold_to;
    t_event            w_ev;
    logic              w_bad;
    logic              w_q;

    assign o_pop       = !i_empty && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_event_res = r_event;
    assign o_position  = r_pos;
    assign o_quoted    = r_quoted;
    assign o_error     = r_error;
    assign w_fold_to   = (i_item.cls == CLS_LF) ? PS_LF : PS_CR;

    // next state of the recognizer for one byte
    always_comb begin
        w_ns = r_pstate;
        w_nf = r_fold;
        case (i_item.cls)
            CLS_WS: begin
                case (r_pstate)
                    PS_FQVAL, PS_SKIPQ:      w_ns = PS_QVAL;
                    PS_TYPE:                 w_ns = PS_ETYPE;
                    PS_PARAM:                w_ns = PS_EPARAM;
                    PS_VAL:                  w_ns = PS_EVAL;
                    PS_LF, PS_CR, PS_CRLF:   w_ns = r_fold;
                    default:                 w_ns = r_pstate;
                endcase
            end
            CLS_LF, CLS_CR: begin
                case (r_pstate)
                    PS_TYPE: begin
                        w_nf = PS_ETYPE;
                        w_ns = w_fold_to;
                    end
                    PS_PARAM: begin
                        w_nf = PS_EPARAM;
                        w_ns = w_fold_to;
                    end
                    PS_VAL: begin
                        w_nf = PS_EVAL;
                        w_ns = w_fold_to;
                    end
                    PS_FTYPE, PS_FPARAM: begin
                        w_nf = r_pstate;
                        w_ns = w_fold_to;
                    end
                    PS_CR: begin
                        if (i_item.cls == CLS_LF) begin
                            w_ns = PS_CRLF;
                        end
                    end
                    default: w_ns = r_pstate;
                endcase
            end
            CLS_SEMI: begin
                case (r_pstate)
                    PS_FQVAL, PS_SKIPQ:                     w_ns = PS_QVAL;
                    PS_VAL, PS_PARAM, PS_TYPE, PS_ETYPE,
                    PS_EVAL:                                w_ns = PS_FPARAM;
                    default:                                w_ns = r_pstate;
                endcase
            end
            CLS_EQ: begin
                case (r_pstate)
                    PS_FQVAL, PS_SKIPQ:  w_ns = PS_QVAL;
                    PS_PARAM, PS_EPARAM: w_ns = PS_FVAL;
                    default:             w_ns = r_pstate;
                endcase
            end
            CLS_DQUOTE: begin
                case (r_pstate)
                    PS_SKIPQ: w_ns = PS_QVAL;
                    PS_FVAL:  w_ns = PS_FQVAL;
                    PS_QVAL:  w_ns = PS_EVAL;
                    default:  w_ns = r_pstate;
                endcase
            end
            CLS_BSLASH: begin
                case (r_pstate)
                    PS_FQVAL, PS_QVAL: w_ns = PS_SKIPQ;
                    PS_SKIPQ:          w_ns = PS_QVAL;
                    default:           w_ns = r_pstate;
                endcase
            end
            CLS_SEP: begin
                case (r_pstate)
                    PS_FQVAL, PS_SKIPQ: w_ns = PS_QVAL;
                    default:            w_ns = r_pstate;
                endcase
            end
            CLS_OTHER: begin
                case (r_pstate)
                    PS_SKIPQ, PS_FQVAL: w_ns = PS_QVAL;
                    PS_FTYPE:           w_ns = PS_TYPE;
                    PS_FPARAM:          w_ns = PS_PARAM;
                    PS_FVAL:            w_ns = PS_VAL;
                    default:            w_ns = r_pstate;
                endcase
            end
            default: w_ns = r_pstate;
        endcase
    end

    // event, error and quote flag for one byte
    always_comb begin
        w_ev  = EV_NONE;
        w_bad = 1'b0;
        w_q   = 1'b0;
        case (i_item.cls)
            CLS_WS: begin
                case (r_pstate)
                    PS_FQVAL: w_ev = EV_VAL_START;
                    PS_TYPE:  w_ev = EV_TYPE_END;
                    PS_PARAM: w_ev = EV_NAME_END;
                    PS_VAL:   w_ev = EV_VAL_END;
                    default:  w_ev = EV_NONE;
                endcase
            end
            CLS_LF, CLS_CR: begin
                case (r_pstate)
                    PS_TYPE:             w_ev  = EV_TYPE_END;
                    PS_PARAM:            w_ev  = EV_NAME_END;
                    PS_VAL:              w_ev  = EV_VAL_END;
                    PS_FTYPE, PS_FPARAM: w_ev  = EV_NONE;
                    PS_CR:               w_bad = (i_item.cls == CLS_CR);
                    default:             w_bad = 1'b1;
                endcase
            end
            CLS_NUL: w_bad = 1'b1;
            CLS_SEMI: begin
                case (r_pstate)
                    PS_FQVAL:                     w_ev = EV_VAL_START;
                    PS_VAL:                       w_ev = EV_VAL_END;
                    PS_PARAM:                     w_ev = EV_NAME_END;
                    PS_TYPE:                      w_ev = EV_TYPE_END;
                    PS_SKIPQ, PS_QVAL, PS_ETYPE,
                    PS_EVAL:                      w_ev = EV_NONE;
                    default:                      w_bad = 1'b1;
                endcase
            end
            CLS_EQ: begin
                case (r_pstate)
                    PS_FQVAL:                     w_ev = EV_VAL_START;
                    PS_PARAM:                     w_ev = EV_NAME_END;
                    PS_SKIPQ, PS_QVAL, PS_EPARAM: w_ev = EV_NONE;
                    default:                      w_bad = 1'b1;
                endcase
            end
            CLS_DQUOTE: begin
                case (r_pstate)
                    PS_QVAL: begin
                        w_ev = EV_VAL_END;
                        w_q  = 1'b1;
                    end
                    PS_SKIPQ, PS_FVAL: w_ev = EV_NONE;
                    default:           w_bad = 1'b1;
                endcase
            end
            CLS_BSLASH: begin
                case (r_pstate)
                    PS_FQVAL:          w_ev = EV_VAL_START;
                    PS_SKIPQ, PS_QVAL: w_ev = EV_NONE;
                    default:           w_bad = 1'b1;
                endcase
            end
            CLS_SEP: begin
                case (r_pstate)
                    PS_FQVAL:          w_ev = EV_VAL_START;
                    PS_SKIPQ, PS_QVAL: w_ev = EV_NONE;
                    default:           w_bad = 1'b1;
                endcase
            end
            CLS_OTHER: begin
                case (r_pstate)
                    PS_FTYPE:           w_ev = EV_TYPE_START;
                    PS_FPARAM:          w_ev = EV_NAME_START;
                    PS_FVAL, PS_FQVAL:  w_ev = EV_VAL_START;
                    default:            w_ev = EV_NONE;
                endcase
            end
            default: w_bad = 1'b1;
        endcase
    end

    // apply one item: end check, length cap or byte step
    always_comb begin
        n_pstate = r_pstate;
        n_fold   = r_fold;
        n_offset = r_offset;
        n_err    = r_err;
        n_event  = EV_NONE;
        n_quoted = 1'b0;
        n_error  = r_err;
        if (i_item.cmd == CMD_END) begin
            n_event = EV_DONE;
            if (!r_err) begin
                case (r_pstate)
                    PS_ETYPE, PS_EPARAM, PS_EVAL: n_event = EV_DONE;
                    PS_TYPE:                      n_event = EV_TYPE_END;
                    PS_PARAM:                     n_event = EV_NAME_END;
                    PS_VAL:                       n_event = EV_VAL_END;
                    default:                      n_error = 1'b1;
                endcase
            end
            n_pstate = PS_FTYPE;
            n_fold   = PS_FTYPE;
            n_offset = '0;
            n_err    = 1'b0;
        end else if (r_offset >= POS_CAP) begin
            n_err   = 1'b1;
            n_error = 1'b1;
        end else begin
            n_offset = r_offset + 1'b1;
            if (!r_err) begin
                if (w_bad) begin
                    n_err   = 1'b1;
                    n_error = 1'b1;
                end else begin
                    n_pstate = w_ns;
                    n_fold   = w_nf;
                    n_event  = w_ev;
                    n_quoted = w_q;
                end
            end
        end
        n_out_valid = o_pop || (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate    <= PS_FTYPE;
            r_fold      <= PS_FTYPE;
            r_offset    <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_pstate <= n_pstate;
                r_fold   <= n_fold;
                r_offset <= n_offset;
                r_err    <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event  <= n_event;
            r_pos    <= r_offset;
            r_quoted <= n_quoted;
            r_error  <= n_error;
        end
    end

endmodule
